>>> src/lfcr_pkg.sv
package lfcr_pkg;

	// Field widths of the request and result channels, and of config and counters
	localparam int OP_W      = 2;
	localparam int BYTE_W    = 8;
	localparam int RADDR_W   = 11;
	localparam int STATE_W   = 3;
	localparam int TIMEOUT_W = 17;
	localparam int PTR_W     = 18;
	localparam int COUNT_W   = 16;

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 17'd65536;

	// Request operations
	typedef enum logic [OP_W-1:0] {
		OP_BYTE = 2'd0,
		OP_TICK = 2'd1,
		OP_READ = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	// Command bytes seen in ready or disconnected
	localparam logic [BYTE_W-1:0] CMD_FILL = 8'h01;
	localparam logic [BYTE_W-1:0] CMD_SHOW = 8'h02;
	localparam logic [BYTE_W-1:0] CMD_COPY = 8'h03;

	// Parser modes, as reported on parser_state
	typedef enum logic [STATE_W-1:0] {
		MODE_DISC    = 3'd0,
		MODE_READY   = 3'd1,
		MODE_READING = 3'd2,
		MODE_IDX_HI  = 3'd3,
		MODE_IDX_LO  = 3'd4,
		MODE_CNT_HI  = 3'd5,
		MODE_CNT_LO  = 3'd6,
		MODE_COPYING = 3'd7
	} mode_t;

	// Sequencer states
	typedef enum logic [5:0] {
		SEQ_CLEAR = 6'b000001,
		SEQ_IDLE  = 6'b000010,
		SEQ_EXEC  = 6'b000100,
		SEQ_COPY  = 6'b001000,
		SEQ_RDATA = 6'b010000,
		SEQ_DONE  = 6'b100000
	} seq_t;

endpackage

>>> src/lfcr_req_if.sv
interface lfcr_req_if;
	logic                             valid;
	logic                             ready;
	logic [lfcr_pkg::OP_W-1:0]        op;
	logic [lfcr_pkg::BYTE_W-1:0]      data_byte;
	logic [lfcr_pkg::RADDR_W-1:0]     read_address;

	modport source (output valid, output op, output data_byte, output read_address,
		input ready);
	modport sink (input valid, input op, input data_byte, input read_address,
		output ready);
endinterface

>>> src/lfcr_res_if.sv
interface lfcr_res_if;
	logic                             valid;
	logic                             ready;
	logic                             show_frame;
	logic                             connected;
	logic [lfcr_pkg::STATE_W-1:0]     parser_state;
	logic [lfcr_pkg::BYTE_W-1:0]      read_data;

	modport source (output valid, output show_frame, output connected,
		output parser_state, output read_data, input ready);
	modport sink (input valid, input show_frame, input connected,
		input parser_state, input read_data, output ready);
endinterface

>>> src/lfcr_ram.sv
module lfcr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one entry, register the read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> src/led_frame_command_receiver_unit.sv
// Flow: an accepted byte, tick or idle op passes through the EXEC and DONE states, a read
// also through RDATA; a copy colour byte adds a COPY walk (at most its count of entries).
// The single-item sequencer takes no new request until the result is handed over; it sits
// around the frame store RAM, which takes one write per cycle during a copy walk.
// Reset: arst_n clears all control state, then a clearing pass writes zero to all
// 3*NUM_LEDS store bytes, one per cycle, with request.ready low; config writes still land.
module led_frame_command_receiver_unit #(
	parameter int NUM_LEDS = 512
) (
	input  logic                               clk,
	input  logic                               arst_n,
	lfcr_req_if.sink                           request,
	lfcr_res_if.source                         result,
	input  logic                               cfg_write_enable,
	input  logic [lfcr_pkg::TIMEOUT_W-1:0]     cfg_write_data
);

	localparam int STORE_BYTES = 3 * NUM_LEDS;
	localparam int AW          = $clog2(STORE_BYTES);
	localparam logic [lfcr_pkg::PTR_W:0]   STORE_W   = (lfcr_pkg::PTR_W + 1)'(STORE_BYTES);
	localparam logic [lfcr_pkg::PTR_W-1:0] STORE_PTR = lfcr_pkg::PTR_W'(STORE_BYTES);
	localparam logic [AW-1:0]              LAST_ADDR = AW'(STORE_BYTES - 1);

	lfcr_pkg::seq_t  seq_q;
	lfcr_pkg::mode_t mode_q;

	logic [lfcr_pkg::TIMEOUT_W-1:0] timeout_q;
	logic [lfcr_pkg::TIMEOUT_W-1:0] idle_q;
	logic [lfcr_pkg::PTR_W-1:0]     wp_q;
	logic [lfcr_pkg::PTR_W-1:0]     wend_q;
	logic [lfcr_pkg::COUNT_W-1:0]   repeat_q;
	logic [lfcr_pkg::BYTE_W-1:0]    hold_q;
	logic [AW-1:0]                  clr_q;
	logic [lfcr_pkg::PTR_W:0]       walk_q;
	logic [lfcr_pkg::COUNT_W-1:0]   cnt_q;

	// Captured request
	lfcr_pkg::op_t                  op_q;
	logic [lfcr_pkg::BYTE_W-1:0]    byte_q;
	logic [lfcr_pkg::RADDR_W-1:0]   addr_q;

	// Pending result and output register
	logic                           show_q;
	logic                           rd_ok_q;
	logic [lfcr_pkg::BYTE_W-1:0]    rd_q;
	logic                           out_valid_q;
	logic                           out_show_q;
	logic                           out_conn_q;
	logic [lfcr_pkg::STATE_W-1:0]   out_state_q;
	logic [lfcr_pkg::BYTE_W-1:0]    out_rd_q;

	logic                           ram_we;
	logic [AW-1:0]                  ram_waddr;
	logic [lfcr_pkg::BYTE_W-1:0]    ram_wdata;
	logic [lfcr_pkg::BYTE_W-1:0]    ram_rdata;

	logic [lfcr_pkg::TIMEOUT_W-1:0] idle_inc;
	logic [lfcr_pkg::PTR_W-1:0]     wp_inc;
	logic                           wp_in_store;
	logic [lfcr_pkg::COUNT_W-1:0]   pair_word;
	logic [lfcr_pkg::PTR_W-1:0]     idx_times3;
	logic [lfcr_pkg::PTR_W:0]       walk_next;
	logic                           out_free;

	lfcr_ram #(
		.WIDTH (lfcr_pkg::BYTE_W),
		.DEPTH (STORE_BYTES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (AW'(addr_q)),
		.rdata (ram_rdata)
	);

	// Arithmetic used by the sequencer
	assign idle_inc    = idle_q + 1'b1;
	assign wp_inc      = wp_q + 1'b1;
	assign wp_in_store = {1'b0, wp_q} < STORE_W;
	assign pair_word   = {hold_q, byte_q};
	assign idx_times3  = {2'b00, pair_word} + {1'b0, pair_word, 1'b0};
	assign walk_next   = walk_q + (lfcr_pkg::PTR_W + 1)'(3);
	assign out_free    = !out_valid_q || result.ready;

	assign request.ready = (seq_q == lfcr_pkg::SEQ_IDLE);

	// Select the store write: clearing pass, fill byte or copy walk
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = '0;
		case (seq_q)
			lfcr_pkg::SEQ_CLEAR: begin
				ram_we = 1'b1;
			end
			lfcr_pkg::SEQ_EXEC: begin
				ram_waddr = wp_q[AW-1:0];
				ram_wdata = byte_q;
				ram_we    = (op_q == lfcr_pkg::OP_BYTE) &&
					(mode_q == lfcr_pkg::MODE_READING) && wp_in_store;
			end
			lfcr_pkg::SEQ_COPY: begin
				ram_waddr = walk_q[AW-1:0];
				ram_wdata = byte_q;
				ram_we    = 1'b1;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// Hold the request payload
	always_ff @(posedge clk) begin
		if (request.valid && request.ready) begin
			op_q   <= lfcr_pkg::op_t'(request.op);
			byte_q <= request.data_byte;
			addr_q <= request.read_address;
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= lfcr_pkg::TIMEOUT_RESET;
		end else if (cfg_write_enable) begin
			timeout_q <= cfg_write_data;
		end
	end

	// Sequencer and parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q    <= lfcr_pkg::SEQ_CLEAR;
			mode_q   <= lfcr_pkg::MODE_DISC;
			idle_q   <= '0;
			wp_q     <= '0;
			wend_q   <= '0;
			repeat_q <= '0;
			hold_q   <= '0;
			clr_q    <= '0;
			walk_q   <= '0;
			cnt_q    <= '0;
			show_q   <= 1'b0;
			rd_ok_q  <= 1'b0;
			rd_q     <= '0;
		end else begin
			case (seq_q)
				// Sweep zeros through the store
				lfcr_pkg::SEQ_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_ADDR) begin
						seq_q <= lfcr_pkg::SEQ_IDLE;
					end
				end
				lfcr_pkg::SEQ_IDLE: begin
					if (request.valid) begin
						seq_q <= lfcr_pkg::SEQ_EXEC;
					end
				end
				// Act on the captured request
				lfcr_pkg::SEQ_EXEC: begin
					show_q <= 1'b0;
					rd_q   <= '0;
					seq_q  <= lfcr_pkg::SEQ_DONE;
					case (op_q)
						lfcr_pkg::OP_BYTE: begin
							idle_q <= '0;
							case (mode_q)
								lfcr_pkg::MODE_READING: begin
									wp_q <= wp_inc;
									if (wp_inc >= wend_q) begin
										mode_q <= lfcr_pkg::MODE_READY;
									end
								end
								lfcr_pkg::MODE_COPYING: begin
									wp_q   <= wp_inc;
									walk_q <= {1'b0, wp_q};
									cnt_q  <= repeat_q;
									if (wp_inc >= wend_q) begin
										mode_q <= lfcr_pkg::MODE_READY;
									end
									if (repeat_q != '0 && wp_in_store) begin
										seq_q <= lfcr_pkg::SEQ_COPY;
									end
								end
								lfcr_pkg::MODE_IDX_HI: begin
									hold_q <= byte_q;
									mode_q <= lfcr_pkg::MODE_IDX_LO;
								end
								lfcr_pkg::MODE_IDX_LO: begin
									wp_q   <= idx_times3;
									wend_q <= idx_times3 + lfcr_pkg::PTR_W'(3);
									mode_q <= lfcr_pkg::MODE_CNT_HI;
								end
								lfcr_pkg::MODE_CNT_HI: begin
									hold_q <= byte_q;
									mode_q <= lfcr_pkg::MODE_CNT_LO;
								end
								lfcr_pkg::MODE_CNT_LO: begin
									repeat_q <= pair_word;
									mode_q   <= lfcr_pkg::MODE_COPYING;
								end
								default: begin
									if (byte_q == lfcr_pkg::CMD_FILL) begin
										wp_q   <= '0;
										wend_q <= STORE_PTR;
										mode_q <= lfcr_pkg::MODE_READING;
									end else if (byte_q == lfcr_pkg::CMD_SHOW) begin
										show_q <= 1'b1;
										mode_q <= lfcr_pkg::MODE_READY;
									end else if (byte_q == lfcr_pkg::CMD_COPY) begin
										mode_q <= lfcr_pkg::MODE_IDX_HI;
									end
								end
							endcase
						end
						lfcr_pkg::OP_TICK: begin
							if (idle_inc >= timeout_q) begin
								mode_q <= lfcr_pkg::MODE_DISC;
								idle_q <= '0;
							end else begin
								idle_q <= idle_inc;
							end
						end
						lfcr_pkg::OP_READ: begin
							rd_ok_q <= (lfcr_pkg::PTR_W + 1)'(addr_q) < STORE_W;
							seq_q   <= lfcr_pkg::SEQ_RDATA;
						end
						default: begin
							seq_q <= lfcr_pkg::SEQ_DONE;
						end
					endcase
				end
				// Walk the copy: one store entry per cycle, stop after the count or at the store end
				lfcr_pkg::SEQ_COPY: begin
					walk_q <= walk_next;
					cnt_q  <= cnt_q - 1'b1;
					if (cnt_q == lfcr_pkg::COUNT_W'(1) || walk_next >= STORE_W) begin
						seq_q <= lfcr_pkg::SEQ_DONE;
					end
				end
				lfcr_pkg::SEQ_RDATA: begin
					rd_q  <= rd_ok_q ? ram_rdata : '0;
					seq_q <= lfcr_pkg::SEQ_DONE;
				end
				// Hand the result over once the output register is free
				lfcr_pkg::SEQ_DONE: begin
					if (out_free) begin
						seq_q <= lfcr_pkg::SEQ_IDLE;
					end
				end
				default: begin
					seq_q <= lfcr_pkg::SEQ_IDLE;
				end
			endcase
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (seq_q == lfcr_pkg::SEQ_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (seq_q == lfcr_pkg::SEQ_DONE && out_free) begin
			out_show_q  <= show_q;
			out_conn_q  <= (mode_q != lfcr_pkg::MODE_DISC);
			out_state_q <= mode_q;
			out_rd_q    <= rd_q;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.show_frame   = out_show_q;
	assign result.connected    = out_conn_q;
	assign result.parser_state = out_state_q;
	assign result.read_data    = out_rd_q;

endmodule
